// ===== rtl/assert_macros.svh =====
// Assertion helpers for the color converter; both assume ports named clock and reset.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every edge outside reset.
`define HSV_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);

// Implication: when pre holds, post holds at the next clock edge.
`define HSV_ASSERT_NEXT(label, pre, post, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (pre) |=> (post)) \
      else $error(msg);

`endif

// ===== rtl/hsv_pkg.sv =====
package hsv_pkg;

   localparam int HUE_W   = 16;
   localparam int PCT_W   = 8;
   localparam int SPCT_W  = 7;   // clamped percent, 0..100
   localparam int LEVEL_W = 16;

   localparam logic [SPCT_W-1:0] PCT_FULL   = 7'd100;
   localparam logic [5:0]        SECTOR_DEG = 6'd60;
   localparam logic [15:0]       HUE_TURN   = 16'd360;

   // hue / 360 as (hue * ceil(2^24 / 360)) >> 24, exact for 16-bit hue
   localparam logic [15:0] HUE_RECIP       = 16'd46604;
   localparam int          HUE_RECIP_SHIFT = 24;
   localparam int          TURNS_W         = 8;
   localparam int          HUE_RED_W       = 9;

   // every level is bright * factor * scale / 600000, factor <= 6000
   localparam int                 FACTOR_W    = 13;
   localparam logic [FACTOR_W-1:0] FACTOR_FULL = 13'd6000;
   localparam int                 PRODUCT_W   = 20;
   localparam int                 SCALED_W    = 36;
   // 600000 = 64 * 9375: shift by 6, then divide by 9375 via reciprocal
   localparam int                 DIV_PRESHIFT = 6;
   localparam int                 QUOT_IN_W    = 30;
   localparam int                 DIV_RECIP_W  = 31;
   localparam logic [DIV_RECIP_W-1:0] DIV_RECIP = 31'd1876499845;
   localparam int                 DIV_SHIFT    = 44;
   localparam int                 DIV_PROD_W   = QUOT_IN_W + DIV_RECIP_W;

   localparam int QUEUE_DEPTH = 2;

   typedef logic [2:0] sector_type;
   localparam sector_type SECTOR_RED_TO_YELLOW    = 3'd0;
   localparam sector_type SECTOR_YELLOW_TO_GREEN  = 3'd1;
   localparam sector_type SECTOR_GREEN_TO_CYAN    = 3'd2;
   localparam sector_type SECTOR_CYAN_TO_BLUE     = 3'd3;
   localparam sector_type SECTOR_BLUE_TO_MAGENTA  = 3'd4;
   localparam sector_type SECTOR_MAGENTA_TO_RED   = 3'd5;

   typedef struct packed {
      sector_type        sector;
      logic [5:0]        rem;
      logic [SPCT_W-1:0] sat;
      logic [SPCT_W-1:0] bright;
   } color_item_type;

   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

endpackage

// ===== rtl/hsv_to_rgb_converter_top.sv =====
// HSB to RGB color converter. Takes one color per clock unless output back-pressure
// fills the queue, and returns one RGB beat per color, in order: two front stages
// reduce the hue modulo 360 and split it into sector and remainder while clamping
// saturation and brightness to 100, a short queue sits between front and back, and
// four back stages build the levels with exact integer math truncated toward zero
// (factor select, brightness multiply, full-scale shift-subtract, reciprocal divide).
// The throughput limit is one color per cycle, set by the back pipeline advancing once
// per clock while the output is not stalled. csr_write_data selects the full scale: 1
// gives 4095, 0 gives 65535; change it only while no color is in flight.
`include "assert_macros.svh"

module hsv_to_rgb_converter_top #(
   parameter int QUEUE_DEPTH = hsv_pkg::QUEUE_DEPTH
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_write_enable,
   input  logic                          csr_write_data,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic [hsv_pkg::HUE_W-1:0]     req_hue_degrees,
   input  logic [hsv_pkg::PCT_W-1:0]     req_saturation_pct,
   input  logic [hsv_pkg::PCT_W-1:0]     req_brightness_pct,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [hsv_pkg::LEVEL_W-1:0]   rsp_red_level,
   output logic [hsv_pkg::LEVEL_W-1:0]   rsp_green_level,
   output logic [hsv_pkg::LEVEL_W-1:0]   rsp_blue_level
);

   localparam int CNT_W = $clog2(QUEUE_DEPTH+1);

   logic                      twelve_bit_ff;
   logic                      q_push;
   logic                      q_pop;
   hsv_pkg::color_item_type   q_wr_item;
   hsv_pkg::color_item_type   q_rd_item;
   hsv_pkg::queue_status_type q_status;
   logic [CNT_W-1:0]          q_count;

   always_ff @(posedge clock) begin
      if (reset) begin
         twelve_bit_ff <= 1'b0;
      end else if (csr_write_enable) begin
         twelve_bit_ff <= csr_write_data;
      end
   end

   hsv_front u_front (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_hue_degrees    (req_hue_degrees),
      .req_saturation_pct (req_saturation_pct),
      .req_brightness_pct (req_brightness_pct),
      .queue_status       (q_status),
      .queue_push         (q_push),
      .queue_item         (q_wr_item)
   );

   hsv_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_item (q_wr_item),
      .pop       (q_pop),
      .pop_item  (q_rd_item),
      .status    (q_status),
      .count     (q_count)
   );

   hsv_back u_back (
      .clock             (clock),
      .reset             (reset),
      .twelve_bit_output (twelve_bit_ff),
      .queue_status      (q_status),
      .queue_item        (q_rd_item),
      .queue_pop         (q_pop),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_red_level     (rsp_red_level),
      .rsp_green_level   (rsp_green_level),
      .rsp_blue_level    (rsp_blue_level)
   );

   `HSV_ASSERT(a_queue_bound, q_count <= CNT_W'(QUEUE_DEPTH), "queue count above depth")
   `HSV_ASSERT(a_pop_nonempty, !q_pop || (q_count != '0), "pop from empty queue")
   `HSV_ASSERT_NEXT(a_count_track, 1'b1, q_count == $past(q_count) + CNT_W'($past(q_push)) - CNT_W'($past(q_pop)), "queue count out of step")

endmodule

// ===== rtl/hsv_front.sv =====
module hsv_front (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic [hsv_pkg::HUE_W-1:0]     req_hue_degrees,
   input  logic [hsv_pkg::PCT_W-1:0]     req_saturation_pct,
   input  logic [hsv_pkg::PCT_W-1:0]     req_brightness_pct,
   input  hsv_pkg::queue_status_type     queue_status,
   output logic                          queue_push,
   output hsv_pkg::color_item_type       queue_item
);

   logic                               adv;
   logic                               s1_valid_ff;
   logic [hsv_pkg::HUE_W-1:0]          s1_hue_ff;
   logic [hsv_pkg::TURNS_W-1:0]        s1_turns_ff;
   logic [hsv_pkg::SPCT_W-1:0]         s1_sat_ff;
   logic [hsv_pkg::SPCT_W-1:0]         s1_bright_ff;
   logic                               s2_valid_ff;
   hsv_pkg::color_item_type            s2_item_ff;
   hsv_pkg::color_item_type            s2_item_in;
   logic [31:0]                        turn_prod;
   logic [hsv_pkg::SPCT_W-1:0]         sat_clamp;
   logic [hsv_pkg::SPCT_W-1:0]         bright_clamp;
   logic [15:0]                        turn_deg;
   logic [hsv_pkg::HUE_RED_W-1:0]      hue_red;
   logic [hsv_pkg::HUE_RED_W-1:0]      sector_base;
   logic [hsv_pkg::HUE_RED_W-1:0]      deg60;

   assign adv        = !s2_valid_ff || !queue_status.full;
   assign req_ready  = adv;
   assign queue_push = s2_valid_ff && !queue_status.full;
   assign queue_item = s2_item_ff;

   assign turn_prod    = 32'(req_hue_degrees) * 32'(hsv_pkg::HUE_RECIP);
   assign sat_clamp    = (req_saturation_pct > 8'(hsv_pkg::PCT_FULL)) ?
                         hsv_pkg::PCT_FULL : req_saturation_pct[hsv_pkg::SPCT_W-1:0];
   assign bright_clamp = (req_brightness_pct > 8'(hsv_pkg::PCT_FULL)) ?
                         hsv_pkg::PCT_FULL : req_brightness_pct[hsv_pkg::SPCT_W-1:0];

   assign turn_deg = 16'(s1_turns_ff) * hsv_pkg::HUE_TURN;
   assign hue_red  = hsv_pkg::HUE_RED_W'(s1_hue_ff - turn_deg);
   assign deg60    = hsv_pkg::HUE_RED_W'(hsv_pkg::SECTOR_DEG);

   always_comb begin
      s2_item_in.sat    = s1_sat_ff;
      s2_item_in.bright = s1_bright_ff;
      if (hue_red >= 9'(5) * deg60) begin
         s2_item_in.sector = hsv_pkg::SECTOR_MAGENTA_TO_RED;
         sector_base       = 9'(5) * deg60;
      end else if (hue_red >= 9'(4) * deg60) begin
         s2_item_in.sector = hsv_pkg::SECTOR_BLUE_TO_MAGENTA;
         sector_base       = 9'(4) * deg60;
      end else if (hue_red >= 9'(3) * deg60) begin
         s2_item_in.sector = hsv_pkg::SECTOR_CYAN_TO_BLUE;
         sector_base       = 9'(3) * deg60;
      end else if (hue_red >= 9'(2) * deg60) begin
         s2_item_in.sector = hsv_pkg::SECTOR_GREEN_TO_CYAN;
         sector_base       = 9'(2) * deg60;
      end else if (hue_red >= deg60) begin
         s2_item_in.sector = hsv_pkg::SECTOR_YELLOW_TO_GREEN;
         sector_base       = deg60;
      end else begin
         s2_item_in.sector = hsv_pkg::SECTOR_RED_TO_YELLOW;
         sector_base       = '0;
      end
      s2_item_in.rem = 6'(hue_red - sector_base);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
      end else if (adv) begin
         s1_valid_ff <= req_valid;
         s2_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s1_hue_ff    <= req_hue_degrees;
         s1_turns_ff  <= turn_prod[hsv_pkg::HUE_RECIP_SHIFT +: hsv_pkg::TURNS_W];
         s1_sat_ff    <= sat_clamp;
         s1_bright_ff <= bright_clamp;
         s2_item_ff   <= s2_item_in;
      end
   end

endmodule

// ===== rtl/hsv_queue.sv =====
module hsv_queue #(
   parameter int DEPTH = hsv_pkg::QUEUE_DEPTH
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         push,
   input  hsv_pkg::color_item_type      push_item,
   input  logic                         pop,
   output hsv_pkg::color_item_type      pop_item,
   output hsv_pkg::queue_status_type    status,
   output logic [$clog2(DEPTH+1)-1:0]   count
);

   localparam int PTR_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH+1);

   hsv_pkg::color_item_type entry_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff;
   logic [PTR_W-1:0] wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff;
   logic [PTR_W-1:0] rd_ptr_in;
   logic [CNT_W-1:0] count_ff;
   logic [CNT_W-1:0] count_in;

   assign status.full  = (count_ff == CNT_W'(DEPTH));
   assign status.empty = (count_ff == '0);
   assign count        = count_ff;
   assign pop_item     = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH-1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH-1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      count_in = count_ff + CNT_W'(push) - CNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

// ===== rtl/hsv_back.sv =====
module hsv_back (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          twelve_bit_output,
   input  hsv_pkg::queue_status_type     queue_status,
   input  hsv_pkg::color_item_type       queue_item,
   output logic                          queue_pop,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [hsv_pkg::LEVEL_W-1:0]   rsp_red_level,
   output logic [hsv_pkg::LEVEL_W-1:0]   rsp_green_level,
   output logic [hsv_pkg::LEVEL_W-1:0]   rsp_blue_level
);

   localparam int LANES = 3;   // red, green, blue

   logic adv;
   logic b1_valid_ff;
   logic b2_valid_ff;
   logic b3_valid_ff;
   logic b4_valid_ff;

   logic [hsv_pkg::SPCT_W-1:0]     b1_bright_ff;
   logic [hsv_pkg::FACTOR_W-1:0]   b1_factor_ff  [LANES];
   logic [hsv_pkg::FACTOR_W-1:0]   b1_factor_in  [LANES];
   logic [hsv_pkg::PRODUCT_W-1:0]  b2_product_ff [LANES];
   logic [hsv_pkg::QUOT_IN_W-1:0]  b3_scaled_ff  [LANES];
   logic [hsv_pkg::LEVEL_W-1:0]    b4_level_ff   [LANES];

   logic [hsv_pkg::FACTOR_W-1:0]   fv;
   logic [hsv_pkg::FACTOR_W-1:0]   fp;
   logic [hsv_pkg::FACTOR_W-1:0]   fq;
   logic [hsv_pkg::FACTOR_W-1:0]   ft;
   logic [hsv_pkg::SCALED_W-1:0]   scaled     [LANES];
   logic [hsv_pkg::DIV_PROD_W-1:0] quot_prod  [LANES];

   assign adv       = !b4_valid_ff || rsp_ready;
   assign queue_pop = adv && !queue_status.empty;
   assign rsp_valid = b4_valid_ff;

   assign rsp_red_level   = b4_level_ff[0];
   assign rsp_green_level = b4_level_ff[1];
   assign rsp_blue_level  = b4_level_ff[2];

   // factors over a common denominator of 6000
   always_comb begin
      fv = hsv_pkg::FACTOR_FULL;
      fp = 13'(hsv_pkg::SECTOR_DEG) * 13'(hsv_pkg::PCT_FULL - queue_item.sat);
      fq = hsv_pkg::FACTOR_FULL - 13'(queue_item.sat) * 13'(queue_item.rem);
      ft = hsv_pkg::FACTOR_FULL
           - 13'(queue_item.sat) * 13'(hsv_pkg::SECTOR_DEG - queue_item.rem);
      unique case (queue_item.sector)
         hsv_pkg::SECTOR_RED_TO_YELLOW: begin
            b1_factor_in[0] = fv; b1_factor_in[1] = ft; b1_factor_in[2] = fp;
         end
         hsv_pkg::SECTOR_YELLOW_TO_GREEN: begin
            b1_factor_in[0] = fq; b1_factor_in[1] = fv; b1_factor_in[2] = fp;
         end
         hsv_pkg::SECTOR_GREEN_TO_CYAN: begin
            b1_factor_in[0] = fp; b1_factor_in[1] = fv; b1_factor_in[2] = ft;
         end
         hsv_pkg::SECTOR_CYAN_TO_BLUE: begin
            b1_factor_in[0] = fp; b1_factor_in[1] = fq; b1_factor_in[2] = fv;
         end
         hsv_pkg::SECTOR_BLUE_TO_MAGENTA: begin
            b1_factor_in[0] = ft; b1_factor_in[1] = fp; b1_factor_in[2] = fv;
         end
         default: begin
            b1_factor_in[0] = fv; b1_factor_in[1] = fp; b1_factor_in[2] = fq;
         end
      endcase
   end

   // full scale is 2^n - 1, so product * scale is a shift and a subtract
   always_comb begin
      for (int i = 0; i < LANES; i++) begin
         if (twelve_bit_output) begin
            scaled[i] = {4'b0, b2_product_ff[i], 12'b0}
                        - hsv_pkg::SCALED_W'(b2_product_ff[i]);
         end else begin
            scaled[i] = {b2_product_ff[i], 16'b0}
                        - hsv_pkg::SCALED_W'(b2_product_ff[i]);
         end
         quot_prod[i] = hsv_pkg::DIV_PROD_W'(b3_scaled_ff[i])
                        * hsv_pkg::DIV_PROD_W'(hsv_pkg::DIV_RECIP);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         b1_valid_ff <= 1'b0;
         b2_valid_ff <= 1'b0;
         b3_valid_ff <= 1'b0;
         b4_valid_ff <= 1'b0;
      end else if (adv) begin
         b1_valid_ff <= queue_pop;
         b2_valid_ff <= b1_valid_ff;
         b3_valid_ff <= b2_valid_ff;
         b4_valid_ff <= b3_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         b1_bright_ff <= queue_item.bright;
         for (int i = 0; i < LANES; i++) begin
            b1_factor_ff[i]  <= b1_factor_in[i];
            b2_product_ff[i] <= hsv_pkg::PRODUCT_W'(b1_bright_ff)
                                * hsv_pkg::PRODUCT_W'(b1_factor_ff[i]);
            b3_scaled_ff[i]  <= scaled[i][hsv_pkg::DIV_PRESHIFT +: hsv_pkg::QUOT_IN_W];
            b4_level_ff[i]   <= quot_prod[i][hsv_pkg::DIV_SHIFT +: hsv_pkg::LEVEL_W];
         end
      end
   end

endmodule

// ===== bench/hsv_to_rgb_converter_top_test.sv =====
module hsv_to_rgb_converter_top_test;

   localparam int HALF_PERIOD      = 6;
   localparam int RESET_CYCLES     = 6;
   localparam int PIPE_LATENCY     = 7;
   localparam int PHASE_COUNT      = 8;
   localparam int ITEMS_PER_PHASE  = 200;
   localparam int HOLD_ITEMS       = 60;
   localparam int LONG_HOLD_CYCLES = 300;
   localparam int TIMEOUT_CYCLES   = 200000;
   localparam int CORNER_COUNT     = 22;
   localparam longint unsigned FULL_SCALE_12 = 4095;
   localparam longint unsigned FULL_SCALE_16 = 65535;

   typedef struct {
      logic [hsv_pkg::LEVEL_W-1:0] red;
      logic [hsv_pkg::LEVEL_W-1:0] green;
      logic [hsv_pkg::LEVEL_W-1:0] blue;
   } rgb_levels_type;

   class rgb_scoreboard;
      logic           twelve_bit = 1'b0;
      rgb_levels_type expected_rgb[$];
      int             mismatch_count = 0;

      function rgb_levels_type hsv_levels(logic [hsv_pkg::HUE_W-1:0] hue,
                                          logic [hsv_pkg::PCT_W-1:0] sat_in,
                                          logic [hsv_pkg::PCT_W-1:0] bright_in);
         longint unsigned      pct, deg, h, s, v, rem, full, lv, lp, lq, lt;
         hsv_pkg::sector_type  sector;
         rgb_levels_type       rgb;
         pct  = 64'(hsv_pkg::PCT_FULL);
         deg  = 64'(hsv_pkg::SECTOR_DEG);
         h    = 64'(hue) % 64'(hsv_pkg::HUE_TURN);
         s    = (64'(sat_in) > pct) ? pct : 64'(sat_in);
         v    = (64'(bright_in) > pct) ? pct : 64'(bright_in);
         full = twelve_bit ? FULL_SCALE_12 : FULL_SCALE_16;
         sector = hsv_pkg::sector_type'(h / deg);
         rem    = h % deg;
         lv = v * full / pct;
         lp = v * (pct - s) * full / (pct * pct);
         lq = v * (pct * deg - s * rem) * full / (pct * pct * deg);
         lt = v * (pct * deg - s * (deg - rem)) * full / (pct * pct * deg);
         case (sector)
            hsv_pkg::SECTOR_RED_TO_YELLOW: begin
               rgb.red   = hsv_pkg::LEVEL_W'(lv);
               rgb.green = hsv_pkg::LEVEL_W'(lt);
               rgb.blue  = hsv_pkg::LEVEL_W'(lp);
            end
            hsv_pkg::SECTOR_YELLOW_TO_GREEN: begin
               rgb.red   = hsv_pkg::LEVEL_W'(lq);
               rgb.green = hsv_pkg::LEVEL_W'(lv);
               rgb.blue  = hsv_pkg::LEVEL_W'(lp);
            end
            hsv_pkg::SECTOR_GREEN_TO_CYAN: begin
               rgb.red   = hsv_pkg::LEVEL_W'(lp);
               rgb.green = hsv_pkg::LEVEL_W'(lv);
               rgb.blue  = hsv_pkg::LEVEL_W'(lt);
            end
            hsv_pkg::SECTOR_CYAN_TO_BLUE: begin
               rgb.red   = hsv_pkg::LEVEL_W'(lp);
               rgb.green = hsv_pkg::LEVEL_W'(lq);
               rgb.blue  = hsv_pkg::LEVEL_W'(lv);
            end
            hsv_pkg::SECTOR_BLUE_TO_MAGENTA: begin
               rgb.red   = hsv_pkg::LEVEL_W'(lt);
               rgb.green = hsv_pkg::LEVEL_W'(lp);
               rgb.blue  = hsv_pkg::LEVEL_W'(lv);
            end
            default: begin
               rgb.red   = hsv_pkg::LEVEL_W'(lv);
               rgb.green = hsv_pkg::LEVEL_W'(lp);
               rgb.blue  = hsv_pkg::LEVEL_W'(lq);
            end
         endcase
         return rgb;
      endfunction

      function void note_color(logic [hsv_pkg::HUE_W-1:0] hue,
                               logic [hsv_pkg::PCT_W-1:0] sat_in,
                               logic [hsv_pkg::PCT_W-1:0] bright_in);
         expected_rgb.push_back(hsv_levels(hue, sat_in, bright_in));
      endfunction

      function void check_levels(logic [hsv_pkg::LEVEL_W-1:0] red,
                                 logic [hsv_pkg::LEVEL_W-1:0] green,
                                 logic [hsv_pkg::LEVEL_W-1:0] blue);
         rgb_levels_type want;
         if (expected_rgb.size() == 0) begin
            $error("result beat with no color pending: red %0d green %0d blue %0d",
                   red, green, blue);
            mismatch_count++;
            return;
         end
         want = expected_rgb.pop_front();
         if (red !== want.red) begin
            $error("red_level: expected %0d, actual %0d", want.red, red);
            mismatch_count++;
         end
         if (green !== want.green) begin
            $error("green_level: expected %0d, actual %0d", want.green, green);
            mismatch_count++;
         end
         if (blue !== want.blue) begin
            $error("blue_level: expected %0d, actual %0d", want.blue, blue);
            mismatch_count++;
         end
      endfunction
   endclass

   logic                        clock;
   logic                        reset;
   logic                        csr_write_enable;
   logic                        csr_write_data;
   logic                        req_valid;
   logic                        req_ready;
   logic [hsv_pkg::HUE_W-1:0]   req_hue_degrees;
   logic [hsv_pkg::PCT_W-1:0]   req_saturation_pct;
   logic [hsv_pkg::PCT_W-1:0]   req_brightness_pct;
   logic                        rsp_valid;
   logic                        rsp_ready = 1'b0;
   logic [hsv_pkg::LEVEL_W-1:0] rsp_red_level;
   logic [hsv_pkg::LEVEL_W-1:0] rsp_green_level;
   logic [hsv_pkg::LEVEL_W-1:0] rsp_blue_level;

   rgb_scoreboard sb = new();
   int send_idle_pct = 0;
   int sink_stall_pct = 0;
   int hold_request = 0;
   int hold_left = 0;

   // hue turn boundaries, sector edges, and percents at and past full
   logic [hsv_pkg::HUE_W-1:0] corner_hue[CORNER_COUNT] = '{0, 59, 60, 120, 180, 240, 300,
      359, 360, 720, 65535, 30, 30, 30, 90, 150, 210, 270, 330, 65535, 65534, 359};
   logic [hsv_pkg::PCT_W-1:0] corner_sat[CORNER_COUNT] = '{100, 100, 100, 100, 100, 100,
      100, 100, 100, 50, 255, 0, 101, 100, 255, 0, 50, 77, 1, 0, 100, 99};
   logic [hsv_pkg::PCT_W-1:0] corner_bright[CORNER_COUNT] = '{100, 100, 100, 100, 100, 100,
      100, 100, 100, 50, 255, 100, 100, 101, 0, 0, 255, 33, 1, 0, 1, 99};

   hsv_to_rgb_converter_top uut (
      .clock              (clock),
      .reset              (reset),
      .csr_write_enable   (csr_write_enable),
      .csr_write_data     (csr_write_data),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_hue_degrees    (req_hue_degrees),
      .req_saturation_pct (req_saturation_pct),
      .req_brightness_pct (req_brightness_pct),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_red_level      (rsp_red_level),
      .rsp_green_level    (rsp_green_level),
      .rsp_blue_level     (rsp_blue_level)
   );

   always #HALF_PERIOD clock = ~clock;

   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && req_ready)
            sb.note_color(req_hue_degrees, req_saturation_pct, req_brightness_pct);
         if (rsp_valid && rsp_ready)
            sb.check_levels(rsp_red_level, rsp_green_level, rsp_blue_level);
      end
   end

   // receiver: random stalls, plus a long hold-off on request
   always @(posedge clock) begin
      if (hold_request > 0) begin
         hold_left = hold_request;
         hold_request = 0;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(99) >= sink_stall_pct);
      end
   end

   function automatic logic [hsv_pkg::HUE_W-1:0] pick_hue();
      if ($urandom_range(3) == 0)
         return hsv_pkg::HUE_W'($urandom_range(719));
      return hsv_pkg::HUE_W'($urandom_range(65535));
   endfunction

   function automatic logic [hsv_pkg::PCT_W-1:0] pick_pct();
      case ($urandom_range(9))
         0: return '0;
         1: return hsv_pkg::PCT_W'(hsv_pkg::PCT_FULL);
         2: return hsv_pkg::PCT_W'($urandom_range(255, 101));
         default: return hsv_pkg::PCT_W'($urandom_range(100));
      endcase
   endfunction

   task automatic send_color(input logic [hsv_pkg::HUE_W-1:0] hue,
                             input logic [hsv_pkg::PCT_W-1:0] sat_in,
                             input logic [hsv_pkg::PCT_W-1:0] bright_in);
      int gap;
      gap = 0;
      while ($urandom_range(99) < send_idle_pct)
         gap++;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid          <= 1'b1;
      req_hue_degrees    <= hue;
      req_saturation_pct <= sat_in;
      req_brightness_pct <= bright_in;
      do @(posedge clock); while (!req_ready);
   endtask

   task automatic wait_for_drain();
      req_valid <= 1'b0;
      // let the monitor log the last accepted beat before checking the queue
      @(posedge clock);
      while (sb.expected_rgb.size() != 0)
         @(posedge clock);
      repeat (PIPE_LATENCY + 3) @(posedge clock);
   endtask

   task automatic write_scale(input logic twelve_bit);
      csr_write_enable <= 1'b1;
      csr_write_data   <= twelve_bit;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      sb.twelve_bit = twelve_bit;
   endtask

   initial begin
      clock              = 1'b0;
      reset              = 1'b1;
      csr_write_enable   = 1'b0;
      csr_write_data     = 1'b0;
      req_valid          = 1'b0;
      req_hue_degrees    = '0;
      req_saturation_pct = '0;
      req_brightness_pct = '0;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // corners run at the reset full scale
      for (int i = 0; i < CORNER_COUNT; i++)
         send_color(corner_hue[i], corner_sat[i], corner_bright[i]);
      wait_for_drain();

      // back-pressure: output held off while input keeps streaming
      hold_request = LONG_HOLD_CYCLES;
      repeat (HOLD_ITEMS) send_color(pick_hue(), pick_pct(), pick_pct());
      wait_for_drain();

      for (int phase = 0; phase < PHASE_COUNT; phase++) begin
         write_scale(phase % 2 == 0);
         case (phase / 2)
            0: begin send_idle_pct = 0;  sink_stall_pct = 0;  end
            1: begin send_idle_pct = 72; sink_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  sink_stall_pct = 72; end
            default: begin send_idle_pct = 13; sink_stall_pct = 13; end
         endcase
         repeat (ITEMS_PER_PHASE) send_color(pick_hue(), pick_pct(), pick_pct());
         wait_for_drain();
      end

      if (sb.mismatch_count == 0)
         $display("SCOREBOARD CLEAN");
      else
         $display("SCOREBOARD MISMATCH");
      $finish;
   end

   initial begin
      #(2 * HALF_PERIOD * TIMEOUT_CYCLES);
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule
